@@ rtl/xtbd_pkg.sv @@
package xtbd_pkg;

    // Cipher constants
    localparam int          WORD_W  = 32;
    localparam int          ROUND_W = 7;
    localparam int          CFG_IDX_W = 3;
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] RESET_ROUNDS = 7'd32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_ROUNDS = 3'd4
    } xtbd_reg_t;

    // Four key words, selected by a two-bit index
    typedef logic [3:0][WORD_W-1:0] xtbd_key_t;

    // One block in flight, with its own sum and round count
    typedef struct packed {
        logic [WORD_W-1:0]  v0;
        logic [WORD_W-1:0]  v1;
        logic [WORD_W-1:0]  sum;
        logic [ROUND_W-1:0] rounds;
    } xtbd_blk_t;

    // Shift-xor-add mixing of one word
    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
        mix_word = ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

@@ rtl/xtea_block_decipher_core.sv @@
// XTEA block decipher, one half round per pipeline stage.
// A block passes the input register and then each half-round stage before m_tvalid.
// Throughput: one block per cycle; the 2*MAX_ROUNDS half-round stages and the
// input register advance together and hold while a result waits on m_tready.
// Reset (synchronous, aresetn low): pipeline emptied, key words zero, round count 32 (or MAX_ROUNDS if smaller).
module xtea_block_decipher_core
    import xtbd_pkg::*;
#(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_W-1:0]    cfg_wdata,
    // Ciphertext stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [31:0] cipher_first, [63:32] cipher_second
    // Plaintext stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata    // [31:0] plain_first, [63:32] plain_second
);

    localparam int                 NUM_HALVES = 2 * MAX_ROUNDS;
    localparam logic [ROUND_W-1:0] MAX_R      = ROUND_W'(MAX_ROUNDS);
    localparam logic [ROUND_W-1:0] RST_R      = (RESET_ROUNDS > MAX_R) ? MAX_R : RESET_ROUNDS;
    localparam logic [WORD_W-1:0]  RST_SUM    = WORD_W'(XTEA_DELTA * WORD_W'(RST_R));

    xtbd_key_t          key_reg;
    xtbd_key_t          key_next;
    logic [ROUND_W-1:0] rounds_reg;
    logic [ROUND_W-1:0] rounds_next;
    logic [WORD_W-1:0]  start_sum_reg;
    logic [WORD_W-1:0]  start_sum_next;
    logic [ROUND_W-1:0] wr_rounds;

    logic                  advance;
    logic [NUM_HALVES:0]   pipe_valid;
    xtbd_blk_t             pipe_blk [0:NUM_HALVES];
    logic                  in_valid_reg;
    xtbd_blk_t             in_blk_reg;

    // Decode configuration writes; saturate the round count and precompute the start sum
    always_comb begin
        key_next       = key_reg;
        rounds_next    = rounds_reg;
        start_sum_next = start_sum_reg;
        wr_rounds      = (cfg_wdata[ROUND_W-1:0] > MAX_R) ? MAX_R : cfg_wdata[ROUND_W-1:0];
        if (cfg_wen) begin
            case (cfg_idx)
                REG_KEY0:   key_next[0] = cfg_wdata;
                REG_KEY1:   key_next[1] = cfg_wdata;
                REG_KEY2:   key_next[2] = cfg_wdata;
                REG_KEY3:   key_next[3] = cfg_wdata;
                REG_ROUNDS: begin
                    rounds_next    = wr_rounds;
                    start_sum_next = WORD_W'(XTEA_DELTA * WORD_W'(wr_rounds));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= '0;
            rounds_reg    <= RST_R;
            start_sum_reg <= RST_SUM;
        end else begin
            key_reg       <= key_next;
            rounds_reg    <= rounds_next;
            start_sum_reg <= start_sum_next;
        end
    end

    // Whole pipeline moves unless the output holds a result not yet taken
    assign advance  = !pipe_valid[NUM_HALVES] || m_tready;
    assign s_tready = advance;

    // Input register: capture the block with its start sum and round count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_blk_reg.v0     <= s_tdata[31:0];
            in_blk_reg.v1     <= s_tdata[63:32];
            in_blk_reg.sum    <= start_sum_reg;
            in_blk_reg.rounds <= rounds_reg;
        end
    end

    assign pipe_valid[0] = in_valid_reg;
    assign pipe_blk[0]   = in_blk_reg;

    // Half-round stages
    for (genvar h = 0; h < NUM_HALVES; h++) begin : g_half
        xtbd_half_round #(
            .HALF_IDX (h)
        ) u_half (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (pipe_valid[h]),
            .in_blk    (pipe_blk[h]),
            .key       (key_reg),
            .out_valid (pipe_valid[h+1]),
            .out_blk   (pipe_blk[h+1])
        );
    end

    assign m_tvalid = pipe_valid[NUM_HALVES];
    assign m_tdata  = {pipe_blk[NUM_HALVES].v1, pipe_blk[NUM_HALVES].v0};

    // Pipeline is empty in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> pipe_valid == '0)
        else $error("pipeline not empty after reset");

    // A stall freezes every stage's valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> pipe_valid == $past(pipe_valid))
        else $error("stage valid changed during stall");

    // Blocks in flight grow by one on an accept with no output taken
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
            $countones(pipe_valid) == $past($countones(pipe_valid)) + 1)
        else $error("block lost or duplicated in pipeline");

    // A taken result with no new input lowers the count by one
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_tvalid && s_tready) && m_tvalid && m_tready) |=>
            $countones(pipe_valid) + 1 == $past($countones(pipe_valid)))
        else $error("pipeline drain count mismatch");

endmodule

@@ rtl/xtbd_half_round.sv @@
module xtbd_half_round
    import xtbd_pkg::*;
#(
    parameter int HALF_IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      in_valid,
    input  xtbd_blk_t in_blk,
    input  xtbd_key_t key,
    output logic      out_valid,
    output xtbd_blk_t out_blk
);

    localparam logic [ROUND_W-1:0] ROUND_NUM = ROUND_W'(HALF_IDX / 2);
    localparam bit                 ODD_HALF  = (HALF_IDX % 2) == 1;

    logic              valid_reg;
    xtbd_blk_t         blk_reg;
    xtbd_blk_t         blk_next;
    logic              active;
    logic [1:0]        key_sel;
    logic [WORD_W-1:0] mix_in;
    logic [WORD_W-1:0] round_f;

    // Undo one half of a round; rounds beyond the block's count pass it on unchanged
    always_comb begin
        active   = ROUND_NUM < in_blk.rounds;
        blk_next = in_blk;
        if (ODD_HALF) begin
            key_sel = in_blk.sum[1:0];
            mix_in  = in_blk.v1;
        end else begin
            key_sel = in_blk.sum[12:11];
            mix_in  = in_blk.v0;
        end
        round_f = mix_word(mix_in) ^ (in_blk.sum + key[key_sel]);
        if (active) begin
            if (ODD_HALF) begin
                blk_next.v0 = in_blk.v0 - round_f;
            end else begin
                blk_next.v1  = in_blk.v1 - round_f;
                blk_next.sum = in_blk.sum - XTEA_DELTA;
            end
        end
    end

    // Advance the stage with the rest of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule
